// File: src/imu_complementary_attitude_macros.svh
// assertion macros for the attitude filter
`ifndef IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_MACROS_SVH

// condition implies consequence in the same cycle
`define IMUCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define IMUCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/imuca_pkg.sv
// constants and tables shared by the attitude filter
package imuca_pkg;

	// cordic and square root datapath widths
	localparam int CW = 50;
	localparam int ZW = 26;
	localparam int SQW = 52;

	// angle limits in q8.7 degrees, and unity in q1.14
	localparam logic signed [15:0] ANG_MAX = 16'sd23040;
	localparam logic signed [15:0] ANG_QUARTER = 16'sd11520;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	// cordic angle units are degrees * 65536
	localparam logic signed [ZW-1:0] DEG90_FINE = 26'sd5898240;
	localparam logic signed [ZW-1:0] DEG180_FINE = 26'sd11796480;
	localparam logic signed [CW-1:0] CORDIC_K30 = 50'sd652032875;
	localparam logic signed [CW-1:0] NORM_LIM = 50'sd1099511627776;
	localparam logic signed [CW-1:0] NORM_FAST = 50'sd4294967296;

	// reciprocal of the tick divisor, scaled by 2^37
	localparam logic signed [31:0] DIV_RECIP = 32'sd68719476;
	localparam logic signed [31:0] DIV_TICK = 32'sd2000;
	localparam int DIV_SHIFT = 37;

	// function codes
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_TILT_W = 2'd0;
	localparam logic [1:0] REG_YAW_W = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	// arctangent of 2^-i in degrees * 65536
	function automatic logic [22:0] atan_tab(input logic [4:0] i);
		logic [22:0] v;
		case (i)
			5'd0: v = 23'd2949120;
			5'd1: v = 23'd1740967;
			5'd2: v = 23'd919879;
			5'd3: v = 23'd466945;
			5'd4: v = 23'd234379;
			5'd5: v = 23'd117304;
			5'd6: v = 23'd58666;
			5'd7: v = 23'd29335;
			5'd8: v = 23'd14668;
			5'd9: v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/imu_complementary_attitude.sv
// attitude filter top level: tilt, compass, magnitudes and complementary blend
// One item is processed at a time. The work is done by three shared units:
// - a single CORDIC unit. It makes three vectoring passes, each a normalization, a
//   quadrant fold and CORDIC_STEPS iterations. It also makes two rotation passes, each
//   of CORDIC_STEPS iterations.
// - a bit-pair square root unit. It makes three passes. The pitch root and the pitch
//   pass are skipped when the y-z accel projection is zero.
// - a 32x32 multiplier. It is stepped through the squares, the heading terms and the
//   blends, and through the tick divisions for each axis.
// in_stall is high from the transfer of an item until its result is placed in the output
// register. A finished result may wait there while the next item is already being worked on.
module imu_complementary_attitude #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] tilt_roll,
	output logic signed [14:0] tilt_pitch,
	output logic signed [15:0] compass_yaw,
	output logic signed [15:0] fused_roll,
	output logic signed [15:0] fused_pitch,
	output logic signed [15:0] fused_yaw,
	output logic signed [15:0] gyro_roll,
	output logic signed [15:0] gyro_pitch,
	output logic signed [15:0] gyro_yaw,
	output logic [15:0]        gravity_magnitude,
	output logic [15:0]        field_magnitude
);
	import imuca_pkg::*;
	`include "imu_complementary_attitude_macros.svh"

	localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

	// sequencer states
	localparam logic [5:0] S_IDLE = 6'd0;
	localparam logic [5:0] S_Q0 = 6'd1;
	localparam logic [5:0] S_Q1 = 6'd2;
	localparam logic [5:0] S_Q2 = 6'd3;
	localparam logic [5:0] S_Q3 = 6'd4;
	localparam logic [5:0] S_Q4 = 6'd5;
	localparam logic [5:0] S_Q5 = 6'd6;
	localparam logic [5:0] S_Q6 = 6'd7;
	localparam logic [5:0] S_RT_G = 6'd8;
	localparam logic [5:0] S_RT_F = 6'd9;
	localparam logic [5:0] S_RT_P = 6'd10;
	localparam logic [5:0] S_ROLL = 6'd11;
	localparam logic [5:0] S_ROLL_W = 6'd12;
	localparam logic [5:0] S_PITCH = 6'd13;
	localparam logic [5:0] S_PITCH_W = 6'd14;
	localparam logic [5:0] S_SCR = 6'd15;
	localparam logic [5:0] S_SCR_W = 6'd16;
	localparam logic [5:0] S_SCP = 6'd17;
	localparam logic [5:0] S_SCP_W = 6'd18;
	localparam logic [5:0] S_M0 = 6'd19;
	localparam logic [5:0] S_M1 = 6'd20;
	localparam logic [5:0] S_M2 = 6'd21;
	localparam logic [5:0] S_M3 = 6'd22;
	localparam logic [5:0] S_M4 = 6'd23;
	localparam logic [5:0] S_M5 = 6'd24;
	localparam logic [5:0] S_M6 = 6'd25;
	localparam logic [5:0] S_M7 = 6'd26;
	localparam logic [5:0] S_YAW = 6'd27;
	localparam logic [5:0] S_YAW_W = 6'd28;
	localparam logic [5:0] S_BL0 = 6'd29;
	localparam logic [5:0] S_BL1 = 6'd30;
	localparam logic [5:0] S_BL2 = 6'd31;
	localparam logic [5:0] S_G0 = 6'd32;
	localparam logic [5:0] S_G1 = 6'd33;
	localparam logic [5:0] S_G2 = 6'd34;
	localparam logic [5:0] S_G3 = 6'd35;
	localparam logic [5:0] S_G4 = 6'd36;
	localparam logic [5:0] S_G5 = 6'd37;
	localparam logic [5:0] S_UPD = 6'd38;
	localparam logic [5:0] S_BY0 = 6'd39;
	localparam logic [5:0] S_BY1 = 6'd40;
	localparam logic [5:0] S_WR = 6'd41;

	// cordic unit states
	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_NORM = 3'd1;
	localparam logic [2:0] C_PRE = 3'd2;
	localparam logic [2:0] C_ITER = 3'd3;
	localparam logic [2:0] C_DONE = 3'd4;

	logic [5:0] state_q;
	logic [1:0] k_q;

	// configuration
	logic [8:0] tilt_w_q, yaw_w_q;
	logic [9:0] period_q;
	logic [8:0] tilt_wt, yaw_wt;

	// captured item
	logic [1:0]         func_q;
	logic signed [15:0] ax_q, ay_q, az_q, mx_q, my_q, mz_q;
	logic signed [15:0] rate_q [3];

	// filter state
	logic signed [15:0] integ_q [3];
	logic signed [15:0] prev_q [3];
	logic signed [15:0] fused_q [2];

	// working registers
	logic [31:0]        syz_q, sa_q, sm_q;
	logic [15:0]        grav_q, field_q;
	logic [25:0]        d_q;
	logic signed [15:0] roll_q, pitch_q, yaw_q, fyaw_q;
	logic signed [15:0] sin_r_q, cos_r_q, sin_p_q, cos_p_q;
	logic signed [47:0] num_q, den_q;
	logic signed [15:0] bl0_q, bl1_q;
	logic               gneg_q;
	logic [26:0]        gu_q;
	logic [16:0]        gq_q;
	logic signed [17:0] inc_q [3];

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;

	// cordic unit
	logic                  cor_start, cor_vec, cor_done;
	logic signed [CW-1:0]  cor_x, cor_y;
	logic signed [15:0]    cor_a;
	logic [2:0]            cst_q;
	logic [4:0]            ci_q;
	logic signed [CW-1:0]  cx_q, cy_q;
	logic signed [ZW-1:0]  cz_q;
	logic                  cvec_q, cneg_q;
	logic signed [CW-1:0]  c_dx, c_dy;
	logic signed [ZW-1:0]  c_tab, c_zfold, c_zin;
	logic                  c_sel, c_fold_neg, c_small, c_fast;
	logic signed [ZW:0]    c_zr;
	logic signed [17:0]    c_ang18;
	logic signed [15:0]    cor_ang;
	logic signed [CW:0]    c_xr, c_yr;
	logic signed [34:0]    c_x35, c_y35;
	logic signed [15:0]    c_xc, c_yc;
	logic signed [15:0]    cor_cos, cor_sin;

	// square root unit
	logic             q_start, q_done_q, qbusy_q;
	logic [SQW-1:0]   q_in, qv_q, qr_q, qb_q, q_trial;
	logic [17:0]      q_round;

	// tick increment and blends
	logic signed [16:0] gsum;
	logic signed [27:0] gn;
	logic signed [27:0] grr;
	logic               grge, grnz;
	logic [16:0]        gq1;
	logic signed [17:0] ginc;
	logic signed [33:0] bl_in_a, bl_in_b;
	logic signed [15:0] bl_out;
	logic signed [17:0] upd_r, upd_p, upd_y;
	logic signed [15:0] upd_rc, upd_pc, upd_yw;
	logic signed [15:0] pitch_c;

	logic out_free, out_load, out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_WR) && out_free;

	// weights saturate at one
	assign tilt_wt = (tilt_w_q > 9'd256) ? 9'd256 : tilt_w_q;
	assign yaw_wt = (yaw_w_q > 9'd256) ? 9'd256 : yaw_w_q;

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		gsum = 17'(rate_q[k_q]) + 17'(prev_q[k_q]);
		unique case (state_q)
			S_Q0: begin mul_a = 32'(ay_q); mul_b = 32'(ay_q); end
			S_Q1: begin mul_a = 32'(az_q); mul_b = 32'(az_q); end
			S_Q2: begin mul_a = 32'(ax_q); mul_b = 32'(ax_q); end
			S_Q3: begin mul_a = 32'(mx_q); mul_b = 32'(mx_q); end
			S_Q4: begin mul_a = 32'(my_q); mul_b = 32'(my_q); end
			S_Q5: begin mul_a = 32'(mz_q); mul_b = 32'(mz_q); end
			S_M0: begin mul_a = 32'(mz_q); mul_b = 32'(sin_r_q); end
			S_M1: begin mul_a = 32'(my_q); mul_b = 32'(cos_r_q); end
			S_M2: begin mul_a = 32'(mx_q); mul_b = 32'(cos_p_q); end
			S_M3: begin mul_a = 32'(my_q); mul_b = 32'(sin_p_q); end
			S_M4: begin mul_a = prod_q[31:0]; mul_b = 32'(sin_r_q); end
			S_M5: begin mul_a = 32'(mz_q); mul_b = 32'(sin_p_q); end
			S_M6: begin mul_a = prod_q[31:0]; mul_b = 32'(cos_r_q); end
			S_G0: begin mul_a = 32'(gsum); mul_b = {22'd0, period_q}; end
			S_G2: begin mul_a = {5'd0, gu_q}; mul_b = DIV_RECIP; end
			S_G4: begin mul_a = {15'd0, gq_q}; mul_b = DIV_TICK; end
			S_BL0: begin
				mul_a = 32'(17'(roll_q) - 17'(integ_q[0]));
				mul_b = {23'd0, tilt_wt};
			end
			S_BL1: begin
				mul_a = 32'(17'(pitch_q) - 17'(integ_q[1]));
				mul_b = {23'd0, tilt_wt};
			end
			S_BY0: begin
				mul_a = 32'(17'(yaw_q) - 17'(integ_q[2]));
				mul_b = {23'd0, yaw_wt};
			end
			default: ;
		endcase
	end

	// blend: b + (a - b) * w / 256, rounded half up
	always_comb begin
		bl_in_b = integ_q[0];
		unique case (state_q)
			S_BL2: bl_in_b = integ_q[1];
			S_BY1: bl_in_b = integ_q[2];
			default: bl_in_b = integ_q[0];
		endcase
		bl_in_a = (bl_in_b <<< 8) + 34'($signed(prod_q[31:0])) + 34'sd128;
		bl_out = bl_in_a[23:8];
	end

	// tick increment: the trapezoid divided by 2000 via reciprocal, rounded half up
	always_comb begin
		gn = $signed(prod_q[27:0]) + 28'sd1000;
		grr = $signed({1'b0, gu_q}) - $signed(prod_q[27:0]);
		grge = (grr >= 28'sd2000);
		gq1 = gq_q + {16'd0, grge};
		grnz = grge ? (grr != 28'sd2000) : (grr != 28'sd0);
		ginc = gneg_q ? -($signed({1'b0, gq1}) + 18'($unsigned(grnz)))
			: $signed({1'b0, gq1});
	end

	// new integrated angles for a tick
	always_comb begin
		upd_r = 18'(fused_q[0]) + inc_q[0];
		upd_p = 18'(fused_q[1]) + inc_q[1];
		upd_y = 18'(integ_q[2]) + inc_q[2];
		if (upd_r > 18'(ANG_MAX)) upd_rc = ANG_MAX;
		else if (upd_r < -18'(ANG_MAX)) upd_rc = -ANG_MAX;
		else upd_rc = upd_r[15:0];
		if (upd_p > 18'(ANG_MAX)) upd_pc = ANG_MAX;
		else if (upd_p < -18'(ANG_MAX)) upd_pc = -ANG_MAX;
		else upd_pc = upd_p[15:0];
		if (upd_y > 18'(ANG_MAX)) upd_yw = 16'(upd_y - 18'sd46080);
		else if (upd_y < -18'(ANG_MAX)) upd_yw = 16'(upd_y + 18'sd46080);
		else upd_yw = upd_y[15:0];
	end

	// pitch from the cordic limited to a quarter turn
	always_comb begin
		if (cor_ang > ANG_QUARTER) pitch_c = ANG_QUARTER;
		else if (cor_ang < -ANG_QUARTER) pitch_c = -ANG_QUARTER;
		else pitch_c = cor_ang;
	end

	// cordic job selection
	always_comb begin
		cor_start = 1'b0;
		cor_vec = 1'b1;
		cor_x = '0;
		cor_y = '0;
		cor_a = roll_q;
		unique case (state_q)
			S_ROLL: begin
				cor_start = 1'b1;
				cor_y = CW'(ay_q);
				cor_x = CW'(az_q);
			end
			S_PITCH: begin
				cor_start = (syz_q != 32'd0);
				cor_y = -(CW'(ax_q) <<< 10);
				cor_x = $signed({24'd0, d_q});
			end
			S_SCR: begin
				cor_start = 1'b1;
				cor_vec = 1'b0;
				cor_a = roll_q;
			end
			S_SCP: begin
				cor_start = 1'b1;
				cor_vec = 1'b0;
				cor_a = pitch_q;
			end
			S_YAW: begin
				cor_start = 1'b1;
				cor_y = $signed({num_q[35:0], 14'd0});
				cor_x = CW'(den_q);
			end
			default: ;
		endcase
	end

	// cordic step and result rounding
	always_comb begin
		c_dx = cx_q >>> ci_q;
		c_dy = cy_q >>> ci_q;
		c_tab = $signed({3'd0, atan_tab(ci_q)});
		c_sel = cvec_q ? !cy_q[CW-1] : cz_q[ZW-1];
		c_small = (cx_q < NORM_LIM) && (cx_q > -NORM_LIM)
			&& (cy_q < NORM_LIM) && (cy_q > -NORM_LIM);
		c_fast = (cx_q < NORM_FAST) && (cx_q > -NORM_FAST)
			&& (cy_q < NORM_FAST) && (cy_q > -NORM_FAST);
		c_zin = ZW'(cor_a) <<< 9;
		c_fold_neg = (c_zin > DEG90_FINE) || (c_zin < -DEG90_FINE);
		if (c_zin > DEG90_FINE) c_zfold = c_zin - DEG180_FINE;
		else if (c_zin < -DEG90_FINE) c_zfold = c_zin + DEG180_FINE;
		else c_zfold = c_zin;
		c_zr = (ZW+1)'(cz_q) + 27'sd256;
		c_ang18 = c_zr[ZW:9];
		if (c_ang18 > 18'(ANG_MAX)) cor_ang = ANG_MAX;
		else if (c_ang18 < -18'(ANG_MAX)) cor_ang = -ANG_MAX;
		else cor_ang = c_ang18[15:0];
		c_xr = (CW+1)'(cx_q) + 51'sd32768;
		c_yr = (CW+1)'(cy_q) + 51'sd32768;
		c_x35 = c_xr[CW:16];
		c_y35 = c_yr[CW:16];
		if (c_x35 > 35'(ONE_Q14)) c_xc = ONE_Q14;
		else if (c_x35 < -35'(ONE_Q14)) c_xc = -ONE_Q14;
		else c_xc = c_x35[15:0];
		if (c_y35 > 35'(ONE_Q14)) c_yc = ONE_Q14;
		else if (c_y35 < -35'(ONE_Q14)) c_yc = -ONE_Q14;
		else c_yc = c_y35[15:0];
		cor_cos = cneg_q ? -c_xc : c_xc;
		cor_sin = cneg_q ? -c_yc : c_yc;
	end

	assign cor_done = (cst_q == C_DONE);

	// cordic control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_IDLE;
			ci_q <= '0;
		end else begin
			unique case (cst_q)
				C_IDLE: begin
					ci_q <= '0;
					if (cor_start) begin
						if (!cor_vec) cst_q <= C_ITER;
						else if (cor_x == '0 && cor_y == '0) cst_q <= C_DONE;
						else cst_q <= C_NORM;
					end
				end
				C_NORM: if (!c_small) cst_q <= C_PRE;
				C_PRE: cst_q <= C_ITER;
				C_ITER: begin
					ci_q <= ci_q + 5'd1;
					if (ci_q == LAST_STEP) cst_q <= C_DONE;
				end
				C_DONE: cst_q <= C_IDLE;
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	// cordic datapath
	always_ff @(posedge clk) begin
		unique case (cst_q)
			C_IDLE: begin
				if (cor_start) begin
					cvec_q <= cor_vec;
					if (cor_vec) begin
						cx_q <= cor_x;
						cy_q <= cor_y;
						cz_q <= '0;
						cneg_q <= 1'b0;
					end else begin
						cx_q <= CORDIC_K30;
						cy_q <= '0;
						cz_q <= c_zfold;
						cneg_q <= c_fold_neg;
					end
				end
			end
			C_NORM: begin
				if (c_fast) begin
					cx_q <= cx_q <<< 8;
					cy_q <= cy_q <<< 8;
				end else if (c_small) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end
			end
			C_PRE: begin
				if (cx_q[CW-1]) begin
					if (!cy_q[CW-1]) begin
						cx_q <= cy_q;
						cy_q <= -cx_q;
						cz_q <= DEG90_FINE;
					end else begin
						cx_q <= -cy_q;
						cy_q <= cx_q;
						cz_q <= -DEG90_FINE;
					end
				end
			end
			C_ITER: begin
				if (c_sel) begin
					cx_q <= cx_q + c_dy;
					cy_q <= cy_q - c_dx;
					cz_q <= cz_q + c_tab;
				end else begin
					cx_q <= cx_q - c_dy;
					cy_q <= cy_q + c_dx;
					cz_q <= cz_q - c_tab;
				end
			end
			default: ;
		endcase
	end

	// square root job selection
	always_comb begin
		q_start = 1'b0;
		q_in = {20'd0, sa_q} << 2;
		unique case (state_q)
			S_Q6: q_start = 1'b1;
			S_RT_G: begin
				q_start = q_done_q;
				q_in = {20'd0, sm_q} << 2;
			end
			S_RT_F: begin
				q_start = q_done_q && (syz_q != 32'd0);
				q_in = {20'd0, syz_q} << 20;
			end
			default: ;
		endcase
		q_trial = qr_q + qb_q;
		q_round = qr_q[17:0] + 18'd1;
	end

	// square root control, one result bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qbusy_q <= 1'b0;
			q_done_q <= 1'b0;
		end else begin
			q_done_q <= 1'b0;
			if (q_start) begin
				qbusy_q <= 1'b1;
			end else if (qbusy_q && qb_q == SQW'(1)) begin
				qbusy_q <= 1'b0;
				q_done_q <= 1'b1;
			end
		end
	end

	// square root datapath
	always_ff @(posedge clk) begin
		if (q_start) begin
			qv_q <= q_in;
			qr_q <= '0;
			qb_q <= SQW'(1) << (SQW - 2);
		end else if (qbusy_q) begin
			if (qv_q >= q_trial) begin
				qv_q <= qv_q - q_trial;
				qr_q <= (qr_q >> 1) + qb_q;
			end else begin
				qr_q <= qr_q >> 1;
			end
			qb_q <= qb_q >> 2;
		end
	end

	// sequencer, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			tilt_w_q <= 9'd205;
			yaw_w_q <= 9'd13;
			period_q <= 10'd100;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				prev_q[i] <= '0;
			end
			fused_q[0] <= '0;
			fused_q[1] <= '0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TILT_W: tilt_w_q <= cfg_data[8:0];
					REG_YAW_W: yaw_w_q <= cfg_data[8:0];
					REG_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end

			// output register handshake
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_Q0;
				S_Q0: state_q <= S_Q1;
				S_Q1: state_q <= S_Q2;
				S_Q2: state_q <= S_Q3;
				S_Q3: state_q <= S_Q4;
				S_Q4: state_q <= S_Q5;
				S_Q5: state_q <= S_Q6;
				S_Q6: state_q <= S_RT_G;
				S_RT_G: if (q_done_q) state_q <= S_RT_F;
				S_RT_F: begin
					if (q_done_q) state_q <= (syz_q != 32'd0) ? S_RT_P : S_ROLL;
				end
				S_RT_P: if (q_done_q) state_q <= S_ROLL;
				S_ROLL: state_q <= S_ROLL_W;
				S_ROLL_W: if (cor_done) state_q <= S_PITCH;
				S_PITCH: state_q <= (syz_q != 32'd0) ? S_PITCH_W : S_SCR;
				S_PITCH_W: if (cor_done) state_q <= S_SCR;
				S_SCR: state_q <= S_SCR_W;
				S_SCR_W: if (cor_done) state_q <= S_SCP;
				S_SCP: state_q <= S_SCP_W;
				S_SCP_W: if (cor_done) state_q <= S_M0;
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_M7;
				S_M7: state_q <= S_YAW;
				S_YAW: state_q <= S_YAW_W;
				S_YAW_W: if (cor_done) state_q <= S_BL0;
				S_BL0: state_q <= S_BL1;
				S_BL1: state_q <= S_BL2;
				S_BL2: begin
					k_q <= '0;
					state_q <= (func_q == FUNC_TICK) ? S_G0 : S_UPD;
				end
				S_G0: state_q <= S_G1;
				S_G1: state_q <= S_G2;
				S_G2: state_q <= S_G3;
				S_G3: state_q <= S_G4;
				S_G4: state_q <= S_G5;
				S_G5: begin
					if (k_q == 2'd2) begin
						state_q <= S_UPD;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_G0;
					end
				end
				S_UPD: begin
					// apply the item to the filter state
					case (func_q)
						FUNC_UPDATE: begin
							fused_q[0] <= bl0_q;
							fused_q[1] <= bl1_q;
						end
						FUNC_TICK: begin
							integ_q[0] <= upd_rc;
							integ_q[1] <= upd_pc;
							integ_q[2] <= upd_yw;
							for (int i = 0; i < 3; i++) prev_q[i] <= rate_q[i];
						end
						FUNC_START: begin
							integ_q[0] <= roll_q;
							integ_q[1] <= pitch_q;
							integ_q[2] <= yaw_q;
							for (int i = 0; i < 3; i++) prev_q[i] <= rate_q[i];
							fused_q[0] <= roll_q;
							fused_q[1] <= pitch_q;
						end
						default: ;
					endcase
					state_q <= S_BY0;
				end
				S_BY0: state_q <= S_BY1;
				S_BY1: state_q <= S_WR;
				S_WR: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		// capture the item on transfer
		if (in_valid && !in_stall) begin
			func_q <= func;
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			mx_q <= mag_x;
			my_q <= mag_y;
			mz_q <= mag_z;
			rate_q[0] <= rate_x;
			rate_q[1] <= rate_y;
			rate_q[2] <= rate_z;
		end

		unique case (state_q)
			S_Q1: syz_q <= prod_q[31:0];
			S_Q2: syz_q <= syz_q + prod_q[31:0];
			S_Q3: sa_q <= syz_q + prod_q[31:0];
			S_Q4: sm_q <= prod_q[31:0];
			S_Q5: sm_q <= sm_q + prod_q[31:0];
			S_Q6: sm_q <= sm_q + prod_q[31:0];
			S_RT_G: if (q_done_q) grav_q <= q_round[16:1];
			S_RT_F: if (q_done_q) field_q <= q_round[16:1];
			S_RT_P: if (q_done_q) d_q <= qr_q[25:0];
			S_ROLL_W: if (cor_done) roll_q <= cor_ang;
			S_PITCH: begin
				// pitch straight up or down when the y-z projection vanishes
				if (syz_q == 32'd0) pitch_q <= (ax_q > 16'sd0) ? ANG_QUARTER : -ANG_QUARTER;
			end
			S_PITCH_W: if (cor_done) pitch_q <= pitch_c;
			S_SCR_W: begin
				if (cor_done) begin
					sin_r_q <= cor_sin;
					cos_r_q <= cor_cos;
				end
			end
			S_SCP_W: begin
				if (cor_done) begin
					sin_p_q <= cor_sin;
					cos_p_q <= cor_cos;
				end
			end
			S_M1: num_q <= $signed(prod_q[47:0]);
			S_M2: num_q <= num_q - $signed(prod_q[47:0]);
			S_M3: den_q <= $signed({prod_q[33:0], 14'd0});
			S_M5: den_q <= den_q + $signed(prod_q[47:0]);
			S_M7: den_q <= den_q + $signed(prod_q[47:0]);
			S_YAW_W: if (cor_done) yaw_q <= cor_ang;
			S_BL1: bl0_q <= bl_out;
			S_BL2: bl1_q <= bl_out;
			S_G1: begin
				gneg_q <= gn[27];
				gu_q <= gn[27] ? 27'(-gn) : gn[26:0];
			end
			S_G3: gq_q <= prod_q[DIV_SHIFT+16:DIV_SHIFT];
			S_G5: inc_q[k_q] <= ginc;
			S_BY1: fyaw_q <= bl_out;
			default: ;
		endcase

		// output register load
		if (out_load) begin
			tilt_roll <= roll_q;
			tilt_pitch <= pitch_q[14:0];
			compass_yaw <= yaw_q;
			fused_roll <= fused_q[0];
			fused_pitch <= fused_q[1];
			fused_yaw <= fyaw_q;
			gyro_roll <= integ_q[0];
			gyro_pitch <= integ_q[1];
			gyro_yaw <= integ_q[2];
			gravity_magnitude <= grav_q;
			field_magnitude <= field_q;
		end
	end

	// checks on the shared units, the integrated roll and the sequencer
	`IMUCA_ASSERT_NOW(a_cordic_start_idle, cor_start, cst_q == C_IDLE,
		"cordic start while busy")
	`IMUCA_ASSERT_NOW(a_sqrt_start_idle, q_start, !qbusy_q, "square root start while busy")
	`IMUCA_ASSERT_NOW(a_roll_range, 1'b1,
		(integ_q[0] <= ANG_MAX) && (integ_q[0] >= -ANG_MAX),
		"integrated roll out of range")
	`IMUCA_ASSERT_NEXT(a_load_then_idle, out_load, (state_q == S_IDLE) && out_valid_q,
		"result load did not end the item")

endmodule

// File: verif/imuca_checker.sv
// watches the attitude filter channels, predicts each result and compares it
`timescale 1ns / 1ps

module imuca_checker #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] tilt_roll,
	input  logic signed [14:0] tilt_pitch,
	input  logic signed [15:0] compass_yaw,
	input  logic signed [15:0] fused_roll,
	input  logic signed [15:0] fused_pitch,
	input  logic signed [15:0] fused_yaw,
	input  logic signed [15:0] gyro_roll,
	input  logic signed [15:0] gyro_pitch,
	input  logic signed [15:0] gyro_yaw,
	input  logic [15:0]        gravity_magnitude,
	input  logic [15:0]        field_magnitude,
	output int                 errors,
	output int                 pending
);
	import imuca_pkg::*;

	localparam longint ANG_LIM = 23040;
	localparam longint QUARTER = 11520;
	localparam longint RIGHT_FINE = 5898240;
	localparam longint HALF_FINE = 11796480;
	localparam longint SCALE_LIM = 64'sd1099511627776;
	localparam longint GAIN_START = 652032875;
	localparam longint UNIT_Q14 = 16384;
	localparam int NSTEP = STEPS > 24 ? 24 : STEPS;

	localparam longint ARC_FINE [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		int f[11];
	} attitude_t;

	localparam string FIELD_NAME [11] = '{
		"tilt_roll", "tilt_pitch", "compass_yaw", "fused_roll", "fused_pitch",
		"fused_yaw", "gyro_roll", "gyro_pitch", "gyro_yaw",
		"gravity_magnitude", "field_magnitude"
	};

	attitude_t attitude_q[$];

	// predictor state and register copies
	int gyro_ang [3];
	int last_rate [3];
	int tilt_mix [2];
	int w_tilt;
	int w_yaw;
	int period;

	function automatic longint lim(longint v, longint m);
		return v > m ? m : (v < -m ? -m : v);
	endfunction

	function automatic longint mag_abs(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring cordic, result in q8.7 degrees
	function automatic int vec_angle(longint y, longint x);
		longint acc, t, dx, dy;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		while (mag_abs(x) < SCALE_LIM && mag_abs(y) < SCALE_LIM) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = RIGHT_FINE;
			end else begin
				x = -y; y = t; acc = -RIGHT_FINE;
			end
		end
		for (int i = 0; i < NSTEP; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; acc += ARC_FINE[i];
			end else begin
				x -= dy; y += dx; acc -= ARC_FINE[i];
			end
		end
		return int'(lim((acc + 256) >>> 9, ANG_LIM));
	endfunction

	// rotation cordic, sine and cosine in q1.14
	task automatic rot_pair(input int a, output longint s, output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(a) * 512;
		x = GAIN_START;
		y = 0;
		flip = 0;
		if (z > RIGHT_FINE) begin
			z -= HALF_FINE; flip = 1;
		end else if (z < -RIGHT_FINE) begin
			z += HALF_FINE; flip = 1;
		end
		for (int i = 0; i < NSTEP; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (z >= 0) begin
				x -= dy; y += dx; z -= ARC_FINE[i];
			end else begin
				x += dy; y -= dx; z += ARC_FINE[i];
			end
		end
		x = lim((x + 32768) >>> 16, UNIT_Q14);
		y = lim((y + 32768) >>> 16, UNIT_Q14);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int vec_len(longint a, longint b, longint c);
		longint unsigned s;
		s = longint'(a * a + b * b + c * c);
		return int'((int_root(s * 4) + 1) >> 1);
	endfunction

	function automatic int mix(int a, int b, int w);
		longint wt;
		wt = w > 256 ? 256 : w;
		return int'((longint'(a) * wt + longint'(b) * (256 - wt) + 128) >>> 8);
	endfunction

	function automatic longint rate_step(int p, int r);
		longint n;
		n = (longint'(p) + r) * period + 1000;
		return n >= 0 ? n / 2000 : -((-n + 1999) / 2000);
	endfunction

	// expected result of one item, advancing the state copy
	task automatic predict_attitude(output attitude_t e);
		longint ax, ay, az, mx, my, mz, sr, cr, sp, cp, num, den, v;
		longint unsigned d;
		int roll, pitch, yaw;
		int rt [3];
		ax = accel_x; ay = accel_y; az = accel_z;
		mx = mag_x; my = mag_y; mz = mag_z;
		rt[0] = rate_x; rt[1] = rate_y; rt[2] = rate_z;
		roll = vec_angle(ay, az);
		if (ay == 0 && az == 0) begin
			pitch = ax > 0 ? QUARTER : -QUARTER;
		end else begin
			d = int_root(longint'(ay * ay + az * az) << 20);
			pitch = int'(lim(vec_angle(-ax * 1024, longint'(d)), QUARTER));
		end
		rot_pair(roll, sr, cr);
		rot_pair(pitch, sp, cp);
		num = (mz * sr - my * cr) * UNIT_Q14;
		den = mx * cp * UNIT_Q14 + my * sp * sr + mz * sp * cr;
		yaw = vec_angle(num, den);
		case (func)
			FUNC_UPDATE: begin
				tilt_mix[0] = mix(roll, gyro_ang[0], w_tilt);
				tilt_mix[1] = mix(pitch, gyro_ang[1], w_tilt);
			end
			FUNC_TICK: begin
				gyro_ang[0] = int'(lim(tilt_mix[0] + rate_step(last_rate[0], rt[0]), ANG_LIM));
				gyro_ang[1] = int'(lim(tilt_mix[1] + rate_step(last_rate[1], rt[1]), ANG_LIM));
				v = gyro_ang[2] + rate_step(last_rate[2], rt[2]);
				if (v > ANG_LIM) v -= 2 * ANG_LIM;
				else if (v < -ANG_LIM) v += 2 * ANG_LIM;
				gyro_ang[2] = int'(v);
				last_rate = rt;
			end
			FUNC_START: begin
				gyro_ang[0] = roll;
				gyro_ang[1] = pitch;
				gyro_ang[2] = yaw;
				last_rate = rt;
				tilt_mix[0] = roll;
				tilt_mix[1] = pitch;
			end
			default: ;
		endcase
		e.f[0] = roll; e.f[1] = pitch; e.f[2] = yaw;
		e.f[3] = tilt_mix[0]; e.f[4] = tilt_mix[1];
		e.f[5] = mix(yaw, gyro_ang[2], w_yaw);
		e.f[6] = gyro_ang[0]; e.f[7] = gyro_ang[1]; e.f[8] = gyro_ang[2];
		e.f[9] = vec_len(ax, ay, az);
		e.f[10] = vec_len(mx, my, mz);
	endtask

	assign pending = attitude_q.size();

	// register copies, prediction on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		attitude_t e;
		attitude_t got;
		if (!arst_n) begin
			gyro_ang = '{0, 0, 0};
			last_rate = '{0, 0, 0};
			tilt_mix = '{0, 0};
			w_tilt = 205;
			w_yaw = 13;
			period = 100;
			errors = 0;
			attitude_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TILT_W: w_tilt = cfg_data[8:0];
					REG_YAW_W: w_yaw = cfg_data[8:0];
					REG_PERIOD: period = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.f[0] = tilt_roll; got.f[1] = tilt_pitch; got.f[2] = compass_yaw;
				got.f[3] = fused_roll; got.f[4] = fused_pitch; got.f[5] = fused_yaw;
				got.f[6] = gyro_roll; got.f[7] = gyro_pitch; got.f[8] = gyro_yaw;
				got.f[9] = gravity_magnitude; got.f[10] = field_magnitude;
				if (attitude_q.size() == 0) begin
					$error("result transfer with no item outstanding");
					errors++;
				end else begin
					e = attitude_q.pop_front();
					for (int i = 0; i < 11; i++) begin
						if (e.f[i] != got.f[i]) begin
							$error("%s expected %0d actual %0d", FIELD_NAME[i], e.f[i],
								got.f[i]);
							errors++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_attitude(e);
				attitude_q.push_back(e);
			end
		end
	end

endmodule

// File: verif/tb_top.sv
// stimulus and verdict for the attitude filter regression
`timescale 1ns / 1ps

module tb_top;
	import imuca_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [9:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = '0;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] mag_x = '0;
	logic signed [15:0] mag_y = '0;
	logic signed [15:0] mag_z = '0;
	logic signed [15:0] rate_x = '0;
	logic signed [15:0] rate_y = '0;
	logic signed [15:0] rate_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic signed [15:0] tilt_roll;
	logic signed [14:0] tilt_pitch;
	logic signed [15:0] compass_yaw;
	logic signed [15:0] fused_roll;
	logic signed [15:0] fused_pitch;
	logic signed [15:0] fused_yaw;
	logic signed [15:0] gyro_roll;
	logic signed [15:0] gyro_pitch;
	logic signed [15:0] gyro_yaw;
	logic [15:0]        gravity_magnitude;
	logic [15:0]        field_magnitude;
	int                 errors;
	int                 pending;

	int burst_left = 0;
	int cycles = 0;

	imu_complementary_attitude dut (.*);
	imuca_checker chk (.*);

	// clock
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("imu_complementary_attitude regression: fail");
			$finish;
		end
	end

	// receiver stall pattern with one long hold-off
	initial begin
		int mode;
		int run;
		int own_cycles;
		mode = 0;
		run = 0;
		own_cycles = 0;
		forever begin
			@(negedge clk);
			own_cycles++;
			if (own_cycles >= 30000 && own_cycles < 36000) begin
				out_stall <= 1'b1;
			end else begin
				if (run == 0) begin
					mode = $urandom_range(0, 2);
					run = $urandom_range(50, 1500);
				end
				run--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// one input transfer, then a gap when the burst is over
	task automatic offer(input logic [1:0] fn, input logic [8:0][15:0] smp);
		int gap;
		@(negedge clk);
		func <= fn;
		{rate_z, rate_y, rate_x, mag_z, mag_y, mag_x, accel_z, accel_y, accel_x} <= smp;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(1, 30);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// register write once the block has drained
	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(input logic [9:0] tw, input logic [9:0] yw, input logic [9:0] per);
		write_reg(REG_TILT_W, tw);
		write_reg(REG_YAW_W, yw);
		write_reg(REG_PERIOD, per);
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom_range(0, 8000) - 4000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_rate();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 20000) - 10000);
	endfunction

	function automatic logic [8:0][15:0] pick_item();
		logic [8:0][15:0] s;
		for (int i = 0; i < 6; i++) s[i] = pick_raw();
		for (int i = 6; i < 9; i++) s[i] = pick_rate();
		return s;
	endfunction

	// directed corners: extremes, zero vectors, degenerate pitch, every func code
	task automatic directed_items();
		logic [8:0][15:0] s;
		s = {9{16'h8000}};
		offer(FUNC_START, s);
		offer(FUNC_UPDATE, s);
		offer(FUNC_TICK, s);
		s = {9{16'h7fff}};
		offer(FUNC_TICK, s);
		offer(FUNC_UPDATE, s);
		offer(FUNC_NONE, s);
		offer(FUNC_START, s);
		s = '0;
		offer(FUNC_UPDATE, s);
		offer(FUNC_START, s);
		// accel only along x: pitch hits a right angle either way
		s[0] = 16'sd1000;
		offer(FUNC_UPDATE, s);
		s[0] = -16'sd1000;
		offer(FUNC_UPDATE, s);
		s[0] = 16'h7fff;
		offer(FUNC_TICK, s);
		s[0] = 16'h8000;
		offer(FUNC_NONE, s);
		for (int i = 0; i < 8; i++) offer(2'(i % 4), pick_item());
	endtask

	// well-formed runs of start, updates and ticks, with some noise
	task automatic random_items(input int n);
		int done;
		int len;
		logic [1:0] fn;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 9) != 0) offer(FUNC_START, pick_item());
			len = $urandom_range(2, 30);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 19))
					0: fn = FUNC_NONE;
					1: fn = FUNC_START;
					2, 3, 4, 5, 6, 7, 8: fn = FUNC_TICK;
					default: fn = FUNC_UPDATE;
				endcase
				offer(fn, pick_item());
			end
			done += len + 1;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_items();
		setup(10'd256, 10'd0, 10'd1);
		directed_items();
		setup(10'd0, 10'd256, 10'd1000);
		random_items(80);
		// weights above full scale, period at its largest value, spare index ignored
		setup(10'd511, 10'd511, 10'd1023);
		write_reg(REG_SPARE, 10'h3ff);
		random_items(80);
		setup(10'd128, 10'd64, 10'd0);
		random_items(60);
		setup(10'd205, 10'd13, 10'd100);
		random_items(RANDOM_ITEMS / 2);
		setup(10'($urandom_range(0, 511)), 10'($urandom_range(0, 511)),
			10'($urandom_range(1, 1000)));
		random_items(RANDOM_ITEMS / 2 - 220);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("imu_complementary_attitude regression: pass");
		end else begin
			$display("imu_complementary_attitude regression: fail");
		end
		$finish;
	end

endmodule
